@@ src/mrf_pkg.sv @@
// Shared constants and controller/datapath signal types for the message ring FIFO.
`timescale 1ns / 1ps

package mrf_pkg;

  localparam int DEF_BUFFER_BYTES       = 1024;
  localparam int DEF_MAX_MESSAGE        = 64;
  localparam int DEF_LENGTH_QUEUE_DEPTH = 64;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_READ    = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  typedef struct packed {
    logic load_in;
    logic load_rd;
    logic do_write;
    logic issue_rd;
    logic emit_rd;
    logic emit_refuse;
  } mrf_cmd_t;

  typedef struct packed {
    logic in_cmd;
    logic rd_ok;
    logic rd_final;
    logic out_free;
  } mrf_stat_t;

endpackage

@@ src/mrf_ctrl.sv @@
// Sequencing state machine for the message ring FIFO.
`timescale 1ns / 1ps

module mrf_ctrl
  import mrf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  mrf_stat_t stat,
  output mrf_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_WRITE   = 3'd2;
  localparam logic [2:0] S_REFUSE  = 3'd3;
  localparam logic [2:0] S_RD_ADDR = 3'd4;
  localparam logic [2:0] S_RD_EMIT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.in_cmd == CMD_WRITE) begin
          state_next = S_WRITE;
        end else if (stat.rd_ok) begin
          cmd.load_rd = 1'b1;
          state_next  = S_RD_ADDR;
        end else begin
          state_next = S_REFUSE;
        end
      end
      S_WRITE: begin
        if (stat.out_free) begin
          cmd.do_write = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_REFUSE: begin
        if (stat.out_free) begin
          cmd.emit_refuse = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_RD_ADDR: begin
        cmd.issue_rd = 1'b1;
        state_next   = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_rd = 1'b1;
          state_next  = stat.rd_final ? S_IDLE : S_RD_ADDR;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/mrf_datapath.sv @@
// Byte ring, length queue, occupancy registers and output register of the message ring FIFO.
`timescale 1ns / 1ps

module mrf_datapath
  import mrf_pkg::*;
#(
  parameter int BUFFER_BYTES       = DEF_BUFFER_BYTES,
  parameter int MAX_MESSAGE        = DEF_MAX_MESSAGE,
  parameter int LENGTH_QUEUE_DEPTH = DEF_LENGTH_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [23:0] s_tdata,
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  input  mrf_cmd_t    cmd,
  output mrf_stat_t   stat
);

  localparam int AW   = $clog2(BUFFER_BYTES);
  localparam int CW   = $clog2(BUFFER_BYTES + 1);
  localparam int QAW  = $clog2(LENGTH_QUEUE_DEPTH);
  localparam int QCW  = $clog2(LENGTH_QUEUE_DEPTH + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  logic [7:0] ring [BUFFER_BYTES];
  logic [6:0] lq   [LENGTH_QUEUE_DEPTH];

  logic        in_cmd;
  logic        in_first;
  logic [7:0]  in_data;
  logic [6:0]  in_mlen;
  logic [6:0]  in_rlen;

  logic [AW-1:0]  widx;
  logic [AW-1:0]  ridx;
  logic [CW-1:0]  count;
  logic [QAW-1:0] qhead;
  logic [QAW-1:0] qtail;
  logic [QCW-1:0] qcount;
  logic [6:0]     head_val;
  logic           accepting;
  logic [6:0]     bytes_left;
  logic [6:0]     pending;
  logic [6:0]     rd_left;
  logic [7:0]     ring_q;
  logic [6:0]     lq_q;

  logic           out_valid;
  logic [7:0]     out_byte;
  logic [1:0]     out_status;
  logic           out_last;
  logic [10:0]    out_stored;
  logic [10:0]    out_free_b;
  logic [6:0]     out_next;

  logic [CW-1:0]  free_now;
  logic           admit;
  logic           acc_eff;
  logic [6:0]     left_eff;
  logic [6:0]     plen_eff;
  logic           store;
  logic [6:0]     left_dec;
  logic           finish;
  logic           push;
  logic [AW-1:0]  widx_inc;
  logic [AW-1:0]  ridx_inc;
  logic [QAW-1:0] qtail_inc;
  logic [QAW-1:0] qhead_inc;
  logic           pop;

  logic [CW-1:0]  count_next;
  logic [QCW-1:0] qcount_next;
  logic [6:0]     head_val_next;
  logic [CW-1:0]  free_next;

  assign free_now  = CW'(BUFFER_BYTES) - count;
  assign widx_inc  = (widx == AW'(BUFFER_BYTES - 1)) ? '0 : widx + 1'b1;
  assign ridx_inc  = (ridx == AW'(BUFFER_BYTES - 1)) ? '0 : ridx + 1'b1;
  assign qtail_inc = (qtail == QAW'(LENGTH_QUEUE_DEPTH - 1)) ? '0 : qtail + 1'b1;
  assign qhead_inc = (qhead == QAW'(LENGTH_QUEUE_DEPTH - 1)) ? '0 : qhead + 1'b1;

  assign admit = (in_mlen != 7'd0) && (in_mlen <= 7'(MAX_MESSAGE))
              && (CMPW'(free_now) > CMPW'(in_mlen))
              && (qcount < QCW'(LENGTH_QUEUE_DEPTH));
  assign acc_eff  = in_first ? admit : accepting;
  assign left_eff = in_first ? (admit ? in_mlen : 7'd0) : bytes_left;
  assign plen_eff = (in_first && admit) ? in_mlen : pending;
  assign store    = acc_eff && (left_eff != 7'd0) && (count < CW'(BUFFER_BYTES));
  assign left_dec = left_eff - 7'd1;
  assign finish   = store && (left_dec == 7'd0);
  assign push     = finish && (qcount < QCW'(LENGTH_QUEUE_DEPTH));
  assign pop      = (rd_left == 7'd1) && (qcount != '0);

  always_comb begin
    count_next    = count;
    qcount_next   = qcount;
    head_val_next = head_val;
    if (cmd.do_write) begin
      if (store) begin
        count_next = count + 1'b1;
      end
      if (push) begin
        qcount_next = qcount + 1'b1;
        if (qcount == '0) begin
          head_val_next = plen_eff;
        end
      end
    end else if (cmd.emit_rd) begin
      count_next = count - 1'b1;
      if (pop) begin
        qcount_next   = qcount - 1'b1;
        head_val_next = lq_q;
      end
    end
  end

  assign free_next = CW'(BUFFER_BYTES) - count_next;

  assign stat.in_cmd   = in_cmd;
  assign stat.rd_ok    = (in_rlen != 7'd0) && (in_rlen <= 7'(MAX_MESSAGE))
                      && (CMPW'(count) >= CMPW'(in_rlen));
  assign stat.rd_final = (rd_left == 7'd1);
  assign stat.out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_cmd   <= s_tuser[0];
      in_first <= s_tuser[1];
      in_data  <= s_tdata[7:0];
      in_mlen  <= s_tdata[14:8];
      in_rlen  <= s_tdata[21:15];
    end
    if (cmd.load_rd) begin
      rd_left <= in_rlen;
    end else if (cmd.emit_rd) begin
      rd_left <= rd_left - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_write && store) begin
      ring[widx] <= in_data;
    end
    if (cmd.issue_rd) begin
      ring_q <= ring[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_write && push) begin
      lq[qtail] <= plen_eff;
    end
    if (cmd.issue_rd) begin
      lq_q <= lq[qhead_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      widx       <= '0;
      ridx       <= '0;
      count      <= '0;
      qhead      <= '0;
      qtail      <= '0;
      qcount     <= '0;
      head_val   <= '0;
      accepting  <= 1'b0;
      bytes_left <= '0;
      pending    <= '0;
    end else begin
      count    <= count_next;
      qcount   <= qcount_next;
      head_val <= head_val_next;
      if (cmd.do_write) begin
        pending <= plen_eff;
        if (store) begin
          widx       <= widx_inc;
          bytes_left <= left_dec;
          accepting  <= !finish;
        end else begin
          bytes_left <= left_eff;
          accepting  <= acc_eff;
        end
        if (push) begin
          qtail <= qtail_inc;
        end
      end
      if (cmd.emit_rd) begin
        ridx <= ridx_inc;
        if (pop) begin
          qhead <= qhead_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_write || cmd.emit_rd || cmd.emit_refuse) begin
      out_stored <= 11'(count_next);
      out_free_b <= 11'(free_next);
      out_next   <= (qcount_next != '0) ? head_val_next : 7'd0;
      out_byte   <= cmd.emit_rd ? ring_q : 8'd0;
      out_last   <= cmd.emit_rd ? (rd_left == 7'd1) : 1'b1;
      if (cmd.do_write) begin
        out_status <= store ? ST_STORED : ST_DROPPED;
      end else if (cmd.emit_rd) begin
        out_status <= ST_READ;
      end else begin
        out_status <= ST_REFUSED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.do_write || cmd.emit_rd || cmd.emit_refuse) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;
  assign m_tdata  = {3'd0, out_next, out_free_b, out_stored, out_byte};

endmodule

@@ src/message_ring_fifo_unit.sv @@
// Top level of the message ring FIFO: controller and datapath.
`timescale 1ns / 1ps

// Byte ring of BUFFER_BYTES entries holding whole messages, with a queue of up to
// LENGTH_QUEUE_DEPTH message lengths. Write words carry one message byte each; the
// first byte admits the message only when its length is 1 to MAX_MESSAGE, free space
// strictly exceeds that length and the length queue has room, else every byte of it
// is dropped. A read word requests a byte count and yields that many bytes (tlast on
// the final one) or one refusal. Every result word reports stored bytes, free bytes
// and the next queued length. Timing: one word at a time; each read byte is fetched
// through the registered read port of the ring memory before it is emitted. Output
// stalls hold the unit; the next input word is taken while a result waits.
module message_ring_fifo_unit
  import mrf_pkg::*;
#(
  parameter int BUFFER_BYTES       = DEF_BUFFER_BYTES,
  parameter int MAX_MESSAGE        = DEF_MAX_MESSAGE,
  parameter int LENGTH_QUEUE_DEPTH = DEF_LENGTH_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // data_byte[7:0], message_length[14:8], read_length[21:15]
  input  logic [1:0]  s_tuser,   // command[0], first_byte[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // byte_out[7:0], stored_bytes[18:8], free_bytes[29:19],
                                 // next_message_size[36:30]
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast
);

  mrf_cmd_t  cmd;
  mrf_stat_t stat;

  mrf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mrf_datapath #(
    .BUFFER_BYTES       (BUFFER_BYTES),
    .MAX_MESSAGE        (MAX_MESSAGE),
    .LENGTH_QUEUE_DEPTH (LENGTH_QUEUE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
